### sv/msbs_pkg.sv
// ---------------------------------------------------------------------------
// msbs_pkg
// shared types and constants of the motor speed and button supervisor
// ---------------------------------------------------------------------------
package msbs_pkg;

   // converter sample width and its full-scale code
   localparam int SAMPLE_BITS = 10;
   localparam int SAMPLE_FULL = (1 << SAMPLE_BITS) - 1;

   localparam int STAMP_BITS = 32;
   localparam int SPEED_BITS = 8;
   localparam int BAR_BITS   = 5;

   localparam logic [SPEED_BITS-1:0] SPEED_MAX = 8'd250;

   // bars = speed * 27 / 250 done as speed * (27 * ceil(2^21 / 250)) >> 21
   localparam int BAR_SHIFT    = 21;
   localparam int BAR_RECIP    = 226503;
   localparam int BAR_RECIP_W  = 18;
   localparam int BAR_PROD_W   = SPEED_BITS + BAR_RECIP_W;

   // stream word layouts, fields packed from bit 0 up, padded to bytes
   localparam int REQ_BITS    = SAMPLE_BITS + 1 + STAMP_BITS;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int REQ_LVL_LSB = SAMPLE_BITS;
   localparam int REQ_NOW_LSB = SAMPLE_BITS + 1;

   localparam int RSP_BITS    = SPEED_BITS + 4 + SPEED_BITS + BAR_BITS;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_OVERSPEED_LIMIT = 2'd0;
   localparam logic [1:0] REG_LONG_PRESS_MS   = 2'd1;
   localparam logic [1:0] REG_OVERSPEED_HOLD  = 2'd2;

   localparam logic [7:0]  OVERSPEED_LIMIT_RST = 8'd240;
   localparam logic [15:0] LONG_PRESS_MS_RST   = 16'd1000;
   localparam logic [15:0] OVERSPEED_HOLD_RST  = 16'd5000;

   typedef struct packed {
      logic [7:0]  overspeed_limit;
      logic [15:0] long_press_ms;
      logic [15:0] overspeed_hold_ms;
   } cfg_type;

   // sample held between the input stage and the supervisor stage
   typedef struct packed {
      logic                  valid;
      logic [SPEED_BITS-1:0] speed;
      logic                  level;
      logic [STAMP_BITS-1:0] now_ms;
   } sample_type;

endpackage

### sv/motor_speed_button_supervisor_core.sv
// ---------------------------------------------------------------------------
// motor_speed_button_supervisor_core
// button-driven run/direction control with overspeed cutoff for a dc motor
// ---------------------------------------------------------------------------
// Takes one control word per cycle while req_tready is high (pot reading,
// button pin level, ms timestamp) and returns one result word per input
// word, in order. A word passes two register stages: the input stage scales
// the pot reading to a 0..250 speed, the supervisor stage updates button,
// run and overspeed state and loads the output register. rsp_tvalid rises
// when the word moves from the input stage into the output register, which
// it does as soon as that register is free or being drained. While a result
// waits in the output register the input stage still takes in one more word,
// then req_tready stays low until rsp_tready frees the output register. The
// user must write registers through the apb port only while no word is in
// flight; the block itself does not enforce this.
module motor_speed_button_supervisor_core (
   input  logic                                clock,
   input  logic                                reset,
   // sample channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [9:0] pot_sample, [10] button_level, [42:11] now_ms, rest zero
   input  logic [msbs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] pwm_duty, [8] drive_in1, [9] drive_in2, [10] motor_running,
   // [11] overspeed_warning, [19:12] speed_level, [24:20] bar_level
   output logic [msbs_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [msbs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [msbs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [msbs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int SB = msbs_pkg::SPEED_BITS;
   localparam int TB = msbs_pkg::STAMP_BITS;

   msbs_pkg::cfg_type    cfg;
   msbs_pkg::sample_type smp;
   logic                 advance;
   logic                 update;

   // supervisor state
   logic          run_ff, run_in;
   logic          cw_ff, cw_in;
   logic          prev_btn_ff, prev_btn_in;
   logic          await_ff, await_in;
   logic [TB-1:0] press_start_ff, press_start_in;
   logic          warn_ff, warn_in;
   logic [TB-1:0] warn_start_ff, warn_start_in;
   logic [SB-1:0] duty_ff, duty_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [msbs_pkg::RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // working signals
   logic                              press_edge;
   logic                              release_edge;
   logic [TB-1:0]                     held_ms;
   logic [TB-1:0]                     over_ms;
   logic                              long_press;
   logic                              run_btn;
   logic                              over;
   logic [msbs_pkg::BAR_PROD_W-1:0]   bar_prod;
   logic [msbs_pkg::BAR_BITS-1:0]     bars;
   logic [SB-1:0]                     speed_shown;

   msbs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   msbs_sample_stage u_sample (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .sample     (smp)
   );

   // output register free or being drained this cycle
   assign advance = !rsp_valid_ff || rsp_tready;
   assign update  = smp.valid && advance;

   always_comb begin
      // button: falling edge arms a press, rising edge ends it
      press_edge   = !smp.level && prev_btn_ff;
      release_edge = smp.level && !prev_btn_ff && await_ff;
      held_ms      = smp.now_ms - press_start_ff;
      long_press   = held_ms >= TB'(cfg.long_press_ms);

      run_btn     = run_ff ^ (release_edge && long_press);
      cw_in       = cw_ff ^ (release_edge && !long_press);
      prev_btn_in = smp.level;

      if (press_edge) await_in = 1'b1;
      else if (release_edge) await_in = 1'b0;
      else await_in = await_ff;

      press_start_in = press_edge ? smp.now_ms : press_start_ff;

      // overspeed: first step arms the timer, later steps check the hold time
      over          = smp.speed > cfg.overspeed_limit;
      over_ms       = smp.now_ms - warn_start_ff;
      run_in        = run_btn;
      warn_in       = 1'b0;
      warn_start_in = warn_start_ff;
      if (run_btn && over) begin
         if (!warn_ff) begin
            warn_start_in = smp.now_ms;
            warn_in       = 1'b1;
         end else if (over_ms >= TB'(cfg.overspeed_hold_ms)) begin
            run_in  = 1'b0;
            warn_in = 1'b0;
         end else begin
            warn_in = 1'b1;
         end
      end

      // duty holds its last value while running over the limit
      if (run_in && !over) duty_in = smp.speed;
      else if (!run_in) duty_in = '0;
      else duty_in = duty_ff;

      bar_prod = msbs_pkg::BAR_PROD_W'(smp.speed)
               * msbs_pkg::BAR_PROD_W'(msbs_pkg::BAR_RECIP);
      bars     = (run_in && !over)
               ? bar_prod[msbs_pkg::BAR_SHIFT +: msbs_pkg::BAR_BITS] : '0;
      speed_shown = run_in ? smp.speed : '0;

      rsp_data_in = {7'd0, bars, speed_shown, warn_in, run_in, !cw_in, cw_in, duty_in};
   end

   always_comb begin
      if (update) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         run_ff         <= 1'b1;
         cw_ff          <= 1'b1;
         prev_btn_ff    <= 1'b1;
         await_ff       <= 1'b0;
         press_start_ff <= '0;
         warn_ff        <= 1'b0;
         warn_start_ff  <= '0;
         duty_ff        <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (update) begin
            run_ff         <= run_in;
            cw_ff          <= cw_in;
            prev_btn_ff    <= prev_btn_in;
            await_ff       <= await_in;
            press_start_ff <= press_start_in;
            warn_ff        <= warn_in;
            warn_start_ff  <= warn_start_in;
            duty_ff        <= duty_in;
         end
      end
   end

   // result payload, loaded only when a new word moves in
   always_ff @(posedge clock) begin
      if (update) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### sv/msbs_csr.sv
// ---------------------------------------------------------------------------
// msbs_csr
// apb register file: overspeed limit, long-press time, overspeed hold time
// ---------------------------------------------------------------------------
module msbs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [msbs_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [msbs_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [msbs_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output msbs_pkg::cfg_type                  cfg
);

   msbs_pkg::cfg_type cfg_ff;
   msbs_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            msbs_pkg::REG_OVERSPEED_LIMIT: cfg_in.overspeed_limit   = pwdata[7:0];
            msbs_pkg::REG_LONG_PRESS_MS:   cfg_in.long_press_ms     = pwdata[15:0];
            msbs_pkg::REG_OVERSPEED_HOLD:  cfg_in.overspeed_hold_ms = pwdata[15:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         msbs_pkg::REG_OVERSPEED_LIMIT: prdata = {24'd0, cfg_ff.overspeed_limit};
         msbs_pkg::REG_LONG_PRESS_MS:   prdata = {16'd0, cfg_ff.long_press_ms};
         msbs_pkg::REG_OVERSPEED_HOLD:  prdata = {16'd0, cfg_ff.overspeed_hold_ms};
         default:                       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.overspeed_limit   <= msbs_pkg::OVERSPEED_LIMIT_RST;
         cfg_ff.long_press_ms     <= msbs_pkg::LONG_PRESS_MS_RST;
         cfg_ff.overspeed_hold_ms <= msbs_pkg::OVERSPEED_HOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/msbs_sample_stage.sv
// ---------------------------------------------------------------------------
// msbs_sample_stage
// input register: unpacks a sample word and scales the pot reading to speed
// ---------------------------------------------------------------------------
module msbs_sample_stage (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [msbs_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                  advance,
   output msbs_pkg::sample_type                  sample
);

   localparam int N      = msbs_pkg::SAMPLE_BITS;
   localparam int PROD_W = N + msbs_pkg::SPEED_BITS;

   logic                                  valid_ff;
   logic                                  valid_in;
   logic [msbs_pkg::SPEED_BITS-1:0]       speed_ff;
   logic [msbs_pkg::SPEED_BITS-1:0]       speed_in;
   logic                                  level_ff;
   logic [msbs_pkg::STAMP_BITS-1:0]       now_ff;
   logic                                  accept;
   logic [N-1:0]                          pot;
   logic [PROD_W-1:0]                     scaled;
   logic [msbs_pkg::SPEED_BITS-1:0]       hi_part;
   logic [N:0]                            fold;

   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign pot        = req_tdata[N-1:0];

   // pot * 250 / (2^N - 1): split x = a*2^N + b, quotient is a plus one
   // when a + b reaches the full-scale code
   always_comb begin
      scaled   = PROD_W'(pot) * PROD_W'(msbs_pkg::SPEED_MAX);
      hi_part  = scaled[PROD_W-1:N];
      fold     = (N+1)'(hi_part) + (N+1)'(scaled[N-1:0]);
      speed_in = hi_part
               + ((fold >= (N+1)'(msbs_pkg::SAMPLE_FULL)) ? 8'd1 : 8'd0);
   end

   always_comb begin
      if (accept) valid_in = 1'b1;
      else if (advance) valid_in = 1'b0;
      else valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         speed_ff <= speed_in;
         level_ff <= req_tdata[msbs_pkg::REQ_LVL_LSB];
         now_ff   <= req_tdata[msbs_pkg::REQ_NOW_LSB +: msbs_pkg::STAMP_BITS];
      end
   end

   assign sample.valid  = valid_ff;
   assign sample.speed  = speed_ff;
   assign sample.level  = level_ff;
   assign sample.now_ms = now_ff;

endmodule

### sv/msbs_checker.sv
// ---------------------------------------------------------------------------
// msbs_checker
// port-level checks on the result channel of the supervisor
// ---------------------------------------------------------------------------
module msbs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [msbs_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   // bridge inputs always opposite
   a_bridge_opposite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[8] != rsp_tdata[9]))
      else $error("bridge inputs not complementary");

   // stopped motor shows nothing and drives nothing
   a_stopped_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[10]) |->
         (rsp_tdata[7:0] == 8'd0 && rsp_tdata[19:12] == 8'd0
          && rsp_tdata[24:20] == 5'd0 && !rsp_tdata[11]))
      else $error("stopped result carries duty, speed, bars or warning");

   // lit bars mean normal running, so the duty tracks the speed
   a_bars_imply_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[24:20] != 5'd0) |->
         (rsp_tdata[7:0] == rsp_tdata[19:12]))
      else $error("bars lit while duty differs from speed");

   // value ranges
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[24:20] <= 5'd27 && rsp_tdata[19:12] <= 8'd250
                      && rsp_tdata[7:0] <= 8'd250))
      else $error("result field out of range");

   // a stalled word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed or dropped");

endmodule

bind motor_speed_button_supervisor_core msbs_checker u_msbs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
